@@ hw/rtl/ps2_mouse_packet_tracker_macros.svh @@
// Assertion macros for the PS/2 mouse packet tracker.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high
`define PS2MT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define PS2MT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2MT_ASSERT(label, clk, rst, prop, msg)
`define PS2MT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/ps2mt_pkg.sv @@
// Package for the PS/2 mouse packet tracker: packet phase type, header bit
// positions, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ps2mt_pkg;

   // Byte position within a three-byte packet
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XDELTA = 2'd1,
      PH_YDELTA = 2'd2,
      PH_UNUSED = 2'd3
   } phase_type;

   // Header bit positions
   localparam int HDR_LEFT_BIT   = 0;
   localparam int HDR_RIGHT_BIT  = 1;
   localparam int HDR_MIDDLE_BIT = 2;
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_X_SIGN_BIT = 4;
   localparam int HDR_Y_SIGN_BIT = 5;
   localparam int HDR_X_OVF_BIT  = 6;
   localparam int HDR_Y_OVF_BIT  = 7;

   // Field widths
   localparam int BYTE_BITS  = 8;
   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int RSP_BITS   = 40;

   // Configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [SIZE_BITS-1:0] RESET_SCREEN_WIDTH  = 16'd1024;
   localparam logic [SIZE_BITS-1:0] RESET_SCREEN_HEIGHT = 16'd768;

endpackage

@@ hw/rtl/ps2_mouse_packet_tracker.sv @@
// PS/2 mouse packet tracker top level: byte framing, cursor update and
// result register. Depends on ps2mt_pkg and ps2_mouse_packet_tracker_macros.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_macros.svh"

// Usage
//   req_* carries one mouse byte per item (req_tdata). The first byte after
//   reset is dropped; then bytes are framed into three-byte packets, and a
//   header byte with bit 3 clear is refused to regain sync.
//   rsp_* carries one item per complete packet: clamped cursor x and y and
//   the three button bits. Header and X bytes give no result.
//   csr_* writes screen_width (index 0) and screen_height (index 1); write
//   them only while no packet is in flight. A new size acts at the next packet.
// Timing
//   One item per cycle while no result waits on rsp_tready. The result of a
//   third byte appears in rsp_tdata in the cycle after its acceptance, set
//   by the single add-and-clamp stage between input and result register.
// Reset and stalls
//   Synchronous reset clears the cursor to 0,0, the packet phase and the
//   pending result, and restores 1024x768. While a result waits with
//   rsp_tready low, req_tready stays low; it rises in the cycle the result is
//   taken, so a waiting result and a new byte move on the same edge.

module ps2_mouse_packet_tracker #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] pos_x, [31:16] pos_y, [32] left_button,
                                    // [33] right_button, [34] middle_button, [39:35] zero
   // configuration
   input  logic        csr_we,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int WIDE_BITS = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;
   localparam logic [WIDE_BITS-1:0] POS_CAP =
      WIDE_BITS'((64'd1 << POSITION_BITS) - 64'd1);

   // Move one axis by a 9-bit signed delta plus optional overflow and inversion, then clamp
   function automatic logic [POSITION_BITS-1:0] apply_axis(
      input logic [POSITION_BITS-1:0] pos,
      input logic [7:0]               delta,
      input logic                     negative,
      input logic                     overflow,
      input logic                     invert,
      input logic [15:0]              size
   );
      logic signed [10:0]          mag;
      logic signed [WIDE_BITS-1:0] sum;
      logic        [WIDE_BITS-1:0] lim;
      logic        [WIDE_BITS-1:0] res;
      mag = $signed({{2{negative}}, negative, delta});
      if (overflow) begin
         mag = negative ? (mag - 11'sd255) : (mag + 11'sd255);
      end
      if (invert) begin
         mag = -mag;
      end
      sum = $signed({{(WIDE_BITS-POSITION_BITS){1'b0}}, pos}) + WIDE_BITS'(mag);
      lim = (size == 16'd0) ? '0 : (WIDE_BITS'(size) - WIDE_BITS'(1));
      if (lim > POS_CAP) begin
         lim = POS_CAP;
      end
      if (sum < 0) begin
         res = '0;
      end else if ($unsigned(sum) > lim) begin
         res = lim;
      end else begin
         res = $unsigned(sum);
      end
      return res[POSITION_BITS-1:0];
   endfunction

   ps2mt_pkg::phase_type     phase_ff, phase_in;
   logic                     skip_ff, skip_in;
   logic [7:0]               header_ff, header_in;
   logic [7:0]               xdelta_ff, xdelta_in;
   logic [POSITION_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [POSITION_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [15:0]              width_ff, height_ff;
   logic                     rsp_valid_ff;
   logic [15:0]              pos_x_ff, pos_y_ff;
   logic [2:0]               buttons_ff;
   logic                     emit;
   logic                     req_accept;
   logic [WIDE_BITS-1:0]     pos_x_wide, pos_y_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Next packet phase
   always_comb begin
      phase_in = phase_ff;
      if (req_accept && !skip_ff) begin
         case (phase_ff)
            ps2mt_pkg::PH_HEADER: begin
               if (req_tdata[ps2mt_pkg::HDR_SYNC_BIT]) begin
                  phase_in = ps2mt_pkg::PH_XDELTA;
               end
            end
            ps2mt_pkg::PH_XDELTA: phase_in = ps2mt_pkg::PH_YDELTA;
            ps2mt_pkg::PH_YDELTA: phase_in = ps2mt_pkg::PH_HEADER;
            default:              phase_in = ps2mt_pkg::PH_HEADER;
         endcase
      end
   end

   // Capture header and X bytes, move the cursor on the Y byte
   always_comb begin
      skip_in     = skip_ff;
      header_in   = header_ff;
      xdelta_in   = xdelta_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      emit        = 1'b0;
      if (req_accept) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else begin
            case (phase_ff)
               ps2mt_pkg::PH_HEADER: begin
                  if (req_tdata[ps2mt_pkg::HDR_SYNC_BIT]) begin
                     header_in = req_tdata;
                  end
               end
               ps2mt_pkg::PH_XDELTA: xdelta_in = req_tdata;
               ps2mt_pkg::PH_YDELTA: begin
                  emit        = 1'b1;
                  cursor_x_in = apply_axis(cursor_x_ff, xdelta_ff,
                                           header_ff[ps2mt_pkg::HDR_X_SIGN_BIT],
                                           header_ff[ps2mt_pkg::HDR_X_OVF_BIT],
                                           1'b0, width_ff);
                  cursor_y_in = apply_axis(cursor_y_ff, req_tdata,
                                           header_ff[ps2mt_pkg::HDR_Y_SIGN_BIT],
                                           header_ff[ps2mt_pkg::HDR_Y_OVF_BIT],
                                           1'b1, height_ff);
               end
               default: emit = 1'b0;
            endcase
         end
      end
   end

   // Hold tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ps2mt_pkg::PH_HEADER;
         skip_ff     <= 1'b1;
         header_ff   <= '0;
         xdelta_ff   <= '0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         skip_ff     <= skip_in;
         header_ff   <= header_in;
         xdelta_ff   <= xdelta_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ps2mt_pkg::RESET_SCREEN_WIDTH;
         height_ff <= ps2mt_pkg::RESET_SCREEN_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            ps2mt_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            ps2mt_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Result valid: set on a finished packet, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign pos_x_wide = WIDE_BITS'(cursor_x_in);
   assign pos_y_wide = WIDE_BITS'(cursor_y_in);

   // Result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         pos_x_ff   <= pos_x_wide[15:0];
         pos_y_ff   <= pos_y_wide[15:0];
         buttons_ff <= {header_ff[ps2mt_pkg::HDR_MIDDLE_BIT],
                        header_ff[ps2mt_pkg::HDR_RIGHT_BIT],
                        header_ff[ps2mt_pkg::HDR_LEFT_BIT]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, buttons_ff, pos_y_ff, pos_x_ff};

   // Checks
   `PS2MT_ASSERT(a_ydelta_gives_result, clock, reset,
      (req_accept && !skip_ff && phase_ff == ps2mt_pkg::PH_YDELTA) |=> rsp_valid_ff,
      "third byte of a packet gave no result")
   `PS2MT_ASSERT(a_skip_keeps_phase, clock, reset,
      (req_accept && skip_ff) |=> (!skip_ff && phase_ff == $past(phase_ff) && !rsp_valid_ff),
      "dropped first byte changed packet state")
   `PS2MT_ASSERT(a_xdelta_advances, clock, reset,
      (req_accept && !skip_ff && phase_ff == ps2mt_pkg::PH_XDELTA)
         |=> (phase_ff == ps2mt_pkg::PH_YDELTA),
      "X byte did not advance to Y byte")
   `PS2MT_ASSERT_ALWAYS(a_no_unused_phase, clock,
      reset || phase_ff != ps2mt_pkg::PH_UNUSED,
      "packet phase reached the unused code")

endmodule

@@ sim/tb_top.sv @@
// Testbench for ps2_mouse_packet_tracker: drives mouse bytes over req_*, predicts
// cursor position and buttons per packet, and checks every rsp_* item in order.
// Depends on ps2mt_pkg and the RTL of ps2_mouse_packet_tracker.
`timescale 1ns / 1ps

module tb_top;
   import ps2mt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int POS_CAP     = (1 << COORD_BITS) - 1;
   localparam int IDLE_TAIL   = 4;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  left;
      logic                  right;
      logic                  middle;
   } cursor_item_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [SIZE_BITS-1:0]      csr_wdata;

   // Predicted block state
   phase_type             trk_phase;
   bit                    trk_skip;
   logic [7:0]            trk_header;
   logic [7:0]            trk_x_byte;
   logic [COORD_BITS-1:0] trk_x;
   logic [COORD_BITS-1:0] trk_y;
   logic [SIZE_BITS-1:0]  trk_width;
   logic [SIZE_BITS-1:0]  trk_height;

   cursor_item_type expected_cursor_q[$];
   int              error_count;
   int              cycle_count;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              send_quiet;
   int              recv_quiet;

   ps2_mouse_packet_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ps2_mouse_packet_tracker: mismatch");
         $finish;
      end
   end

   // Move one axis by a signed 9-bit delta plus optional overflow and inversion, then clamp
   function automatic logic [COORD_BITS-1:0] move_axis(
      input logic [COORD_BITS-1:0] pos, input logic [7:0] delta, input bit negative,
      input bit overflow, input bit invert, input logic [SIZE_BITS-1:0] size);
      int mag;
      int p;
      int lim;
      mag = negative ? -(256 - int'(delta)) : int'(delta);
      if (overflow)
         mag += negative ? -255 : 255;
      if (invert)
         mag = -mag;
      p = int'(pos) + mag;
      lim = (size == 0) ? 0 : int'(size) - 1;
      if (lim > POS_CAP)
         lim = POS_CAP;
      if (p < 0)
         p = 0;
      if (p > lim)
         p = lim;
      return p[COORD_BITS-1:0];
   endfunction

   // Advance the packet framing by one accepted byte; queue a cursor item on the third
   function automatic void track_byte(input logic [7:0] b);
      cursor_item_type item;
      if (trk_skip) begin
         trk_skip = 1'b0;
         return;
      end
      case (trk_phase)
         PH_HEADER: begin
            if (b[HDR_SYNC_BIT]) begin
               trk_header = b;
               trk_phase = PH_XDELTA;
            end
         end
         PH_XDELTA: begin
            trk_x_byte = b;
            trk_phase = PH_YDELTA;
         end
         PH_YDELTA: begin
            trk_phase = PH_HEADER;
            trk_x = move_axis(trk_x, trk_x_byte, trk_header[HDR_X_SIGN_BIT],
                              trk_header[HDR_X_OVF_BIT], 1'b0, trk_width);
            trk_y = move_axis(trk_y, b, trk_header[HDR_Y_SIGN_BIT],
                              trk_header[HDR_Y_OVF_BIT], 1'b1, trk_height);
            item.x = trk_x;
            item.y = trk_y;
            item.left = trk_header[HDR_LEFT_BIT];
            item.right = trk_header[HDR_RIGHT_BIT];
            item.middle = trk_header[HDR_MIDDLE_BIT];
            expected_cursor_q.push_back(item);
         end
         default: trk_phase = PH_HEADER;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   // Present one byte, with random gaps before it, and hold until it is taken
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      taken = 1'b0;
      @(negedge clock);
      if (send_quiet > 0)
         send_quiet--;
      else if ($urandom_range(49) == 0)
         send_quiet = 30;
      while (send_quiet == 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
      end
      track_byte(b);
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                              input logic [7:0] dy);
      send_byte(hdr);
      send_byte(dx);
      send_byte(dy);
   endtask

   // Hold the input until every expected item has come out
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_cursor_q.size() != 0)
         @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   // Close any open packet, drain, then write one size register
   task automatic set_screen(input logic [CSR_INDEX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] value);
      while (trk_phase != PH_HEADER)
         send_byte(8'($urandom_range(255)));
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_wdata <= 16'($urandom_range(65535));
      if (idx == CSR_SCREEN_WIDTH)
         trk_width = value;
      else
         trk_height = value;
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size();
      case ($urandom_range(3))
         0: return 16'($urandom_range(64, 1));
         1: return 16'($urandom_range(2048, 65));
         2: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // Mostly framed packets with random content, some loose noise bytes
   task automatic random_traffic(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(99) < 85) begin
            send_packet(8'($urandom_range(255) | (1 << HDR_SYNC_BIT)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
            sent += 3;
         end else begin
            send_byte(8'($urandom_range(255)));
            sent++;
         end
      end
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      if (recv_quiet > 0)
         recv_quiet <= recv_quiet - 1;
      else if ($urandom_range(99) == 0)
         recv_quiet <= 40;
      rsp_tready <= (recv_quiet > 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each result item with the oldest prediction
   always @(posedge clock) begin
      cursor_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cursor_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[31:0], 32'h0);
         end else begin
            want = expected_cursor_q.pop_front();
            if (rsp_tdata[15:0] !== want.x)
               report_mismatch("pos_x", 32'(rsp_tdata[15:0]), 32'(want.x));
            if (rsp_tdata[31:16] !== want.y)
               report_mismatch("pos_y", 32'(rsp_tdata[31:16]), 32'(want.y));
            if (rsp_tdata[32] !== want.left)
               report_mismatch("left_button", 32'(rsp_tdata[32]), 32'(want.left));
            if (rsp_tdata[33] !== want.right)
               report_mismatch("right_button", 32'(rsp_tdata[33]), 32'(want.right));
            if (rsp_tdata[34] !== want.middle)
               report_mismatch("middle_button", 32'(rsp_tdata[34]), 32'(want.middle));
            if (rsp_tdata[39:35] !== 5'd0)
               report_mismatch("padding", 32'(rsp_tdata[39:35]), 32'h0);
         end
      end
   end

   // Sign, overflow and button decoding at the reset screen size
   task automatic test_directed();
      send_byte(8'h08);          // first byte after reset is dropped
      send_byte(8'h00);          // header without sync bit is refused
      send_byte(8'hF7);
      send_packet(8'h08, 8'h7F, 8'h00);
      send_packet(8'h0F, 8'hFF, 8'h01);
      send_packet(8'h28, 8'h00, 8'h00);
      send_packet(8'hA8, 8'h00, 8'h00);
      send_packet(8'h48, 8'hFF, 8'hFF);
      send_packet(8'h58, 8'h00, 8'h00);
      send_packet(8'h88, 8'h00, 8'hFF);
      send_packet(8'hFF, 8'h80, 8'h80);
   endtask

   // Zero, one and full-range screen sizes
   task automatic test_screen_limits();
      int i;
      set_screen(CSR_SCREEN_WIDTH, 16'd0);
      set_screen(CSR_SCREEN_HEIGHT, 16'd0);
      for (i = 0; i < 4; i++)
         send_packet(8'($urandom_range(255) | 8'h08), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
      set_screen(CSR_SCREEN_WIDTH, 16'hFFFF);
      set_screen(CSR_SCREEN_HEIGHT, 16'hFFFF);
      // push right and down at the largest step until the far corner clamps
      for (i = 0; i < 140; i++)
         send_packet(8'(8'hE8 | $urandom_range(7)), 8'hFF, 8'h00);
      send_packet(8'h58, 8'h00, 8'h7F);
      set_screen(CSR_SCREEN_WIDTH, 16'd1);
      set_screen(CSR_SCREEN_HEIGHT, 16'd1);
      for (i = 0; i < 4; i++)
         send_packet(8'($urandom_range(255) | 8'h08), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
   endtask

   // Random traffic under one idle profile, with a size change halfway
   task automatic test_random(input int send_pct, input int recv_pct, input int n);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      set_screen(CSR_SCREEN_WIDTH, pick_size());
      set_screen(CSR_SCREEN_HEIGHT, pick_size());
      random_traffic(n / 2);
      set_screen(CSR_SCREEN_WIDTH, pick_size());
      set_screen(CSR_SCREEN_HEIGHT, pick_size());
      random_traffic(n - n / 2);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_we = 1'b0;
      csr_index = CSR_SCREEN_WIDTH;
      csr_wdata = 16'h0000;
      send_idle_pct = 11;
      recv_stall_pct = 78;
      send_quiet = 0;
      trk_phase = PH_HEADER;
      trk_skip = 1'b1;
      trk_header = 8'h00;
      trk_x_byte = 8'h00;
      trk_x = '0;
      trk_y = '0;
      trk_width = RESET_SCREEN_WIDTH;
      trk_height = RESET_SCREEN_HEIGHT;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_screen_limits();
      test_random(11, 78, 380);
      test_random(78, 11, 380);
      test_random(0, 0, 380);

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_cursor_q.size() == 0)
         $display("ps2_mouse_packet_tracker: match");
      else
         $display("ps2_mouse_packet_tracker: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ps2mt_pkg.sv
hw/rtl/ps2_mouse_packet_tracker.sv
sim/tb_top.sv
